@@ design/assert_macros.svh @@
// Assertion helpers used by the semaphore RTL.
// Every property is clocked on clock and turned off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/csfw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfw_pkg
// Types and codes for the counting semaphore with a queue of waiting threads.
// ----------------------------------------------------------------------------
package csfw_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int ID_WIDTH    = 8;
   localparam int FUNC_WIDTH  = 3;

   localparam logic [COUNT_WIDTH-1:0] MAX_COUNT_RESET = COUNT_WIDTH'(1);

   localparam logic [FUNC_WIDTH-1:0] FUNC_WAIT     = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_TRYWAIT  = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_POST     = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_GETVALUE = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_DESTROY  = 3'd4;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BUSY    = 2'd1,
      ST_BLOCKED = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic [ID_WIDTH-1:0]   thread_id;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [COUNT_WIDTH-1:0] count_value;
      logic                   woken_valid;
      logic [ID_WIDTH-1:0]    woken_thread;
   } rsp_type;

endpackage

@@ design/counting_semaphore_fifo_waiters_top.sv @@
// Each result passes through the input register, then the result register.
// Throughput: one item per cycle while the result side does not stall.
// The count and queue pointers are updated in the single compute stage,
// and the head of the waiter queue is prefetched from the store each cycle.
// Reset (synchronous, active high): limit and count return to 1, queue empty,
// no item held; the waiter store itself is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_top
// Counting semaphore capped at a programmable limit, with a FIFO of blocked
// thread ids that post releases in arrival order.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  csfw_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output csfw_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [csfw_pkg::COUNT_WIDTH-1:0]   csr_wr_data
);
   import csfw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int WC_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [WC_W-1:0]  FULL_CNT  = WC_W'(QUEUE_DEPTH);

   logic                   in_valid_ff;
   req_type                in_data_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;
   logic [COUNT_WIDTH-1:0] max_ff;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [WC_W-1:0]        wcount_ff, wcount_in;
   logic [ID_WIDTH-1:0]    store [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0]    head_data_ff;

   logic       advance;
   logic       push, pop, do_push, do_pop;
   status_type status;
   rsp_type    rsp_next;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      count_in = count_ff;
      push     = 1'b0;
      pop      = 1'b0;
      status   = ST_OK;
      case (in_data_ff.func)
         FUNC_WAIT: begin
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end else if (wcount_ff == FULL_CNT) begin
               status = ST_FULL;
            end else begin
               push   = 1'b1;
               status = ST_BLOCKED;
            end
         end
         FUNC_TRYWAIT: begin
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end else begin
               status = ST_BUSY;
            end
         end
         FUNC_POST: begin
            if (wcount_ff != '0) begin
               pop = 1'b1;
            end else if (count_ff < max_ff) begin
               count_in = count_ff + 1'b1;
            end else begin
               count_in = max_ff;
            end
         end
         FUNC_GETVALUE: begin
            status = ST_OK;
         end
         FUNC_DESTROY: begin
            if (count_ff != max_ff) begin
               status = ST_BUSY;
            end
         end
         default: begin
            status = ST_BUSY;
         end
      endcase
   end

   assign do_push = advance && push;
   assign do_pop  = advance && pop;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      wcount_in = wcount_ff;
      if (do_pop) begin
         head_in   = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
         wcount_in = wcount_ff - 1'b1;
      end
      if (do_push) begin
         tail_in   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
         wcount_in = wcount_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_next.status       = status;
      rsp_next.count_value  = count_in;
      rsp_next.woken_valid  = pop;
      rsp_next.woken_thread = pop ? head_data_ff : '0;
   end

   // control and semaphore state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= MAX_COUNT_RESET;
         count_ff     <= MAX_COUNT_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         wcount_ff    <= '0;
      end else begin
         if (!in_valid_ff || advance) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // a zero limit is ignored
         if (csr_wr_en && csr_wr_data != '0) begin
            max_ff   <= csr_wr_data;
            count_ff <= csr_wr_data;
         end else if (advance) begin
            count_ff <= count_in;
         end
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         wcount_ff <= wcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // waiter store; read port follows the next head, bypassing a same-slot write
   always_ff @(posedge clock) begin
      if (do_push) begin
         store[tail_ff] <= in_data_ff.thread_id;
      end
      if (do_push && tail_ff == head_in) begin
         head_data_ff <= in_data_ff.thread_id;
      end else begin
         head_data_ff <= store[head_in];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_SAME(a_wcount_bound, 1'b1, wcount_ff <= FULL_CNT)
   `ASSERT_SAME(a_count_bound, 1'b1, count_ff <= max_ff)
   `ASSERT_SAME(a_woken_ok, rsp_valid_ff && rsp_data_ff.woken_valid, rsp_data_ff.status == ST_OK)
   `ASSERT_NEXT(a_pop_dec, do_pop, wcount_ff == WC_W'($past(wcount_ff) - 1'b1))
   `ASSERT_NEXT(a_push_inc, do_push, wcount_ff == WC_W'($past(wcount_ff) + 1'b1))

endmodule

@@ sim/semaphore_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semaphore_checker
// Watches the request, result and register ports of the semaphore. It keeps
// its own copy of the count, the limit and the waiter queue, works out the
// result for every accepted request and compares returned results in order.
// ----------------------------------------------------------------------------
module semaphore_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  csfw_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  csfw_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  logic [csfw_pkg::COUNT_WIDTH-1:0] csr_wr_data,
   output int                               fail_count,
   output int                               pending_count
);
   import csfw_pkg::*;

   logic [COUNT_WIDTH-1:0] sem_limit;
   logic [COUNT_WIDTH-1:0] sem_count;
   logic [ID_WIDTH-1:0]    waiter_ids [QUEUE_DEPTH];
   int                     head_idx;
   int                     tail_idx;
   int                     waiter_total;
   rsp_type                expected_rsps [$];
   rsp_type                want;
   int                     mismatch_total = 0;

   assign fail_count = mismatch_total;

   function automatic rsp_type serve_request(req_type r);
      rsp_type res;
      res.status       = ST_OK;
      res.woken_valid  = 1'b0;
      res.woken_thread = '0;
      case (r.func)
         FUNC_WAIT: begin
            if (sem_count != '0) begin
               sem_count = sem_count - 1'b1;
            end else if (waiter_total >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               waiter_ids[tail_idx] = r.thread_id;
               tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
               waiter_total++;
               res.status = ST_BLOCKED;
            end
         end
         FUNC_TRYWAIT: begin
            if (sem_count != '0) sem_count = sem_count - 1'b1;
            else res.status = ST_BUSY;
         end
         FUNC_POST: begin
            // a waiter takes the post; the count only moves with an empty queue
            if (waiter_total > 0) begin
               res.woken_valid  = 1'b1;
               res.woken_thread = waiter_ids[head_idx];
               head_idx = (head_idx + 1) % QUEUE_DEPTH;
               waiter_total--;
            end else if (sem_count < sem_limit) begin
               sem_count = sem_count + 1'b1;
            end
         end
         FUNC_GETVALUE: begin
         end
         FUNC_DESTROY: begin
            if (sem_count != sem_limit) res.status = ST_BUSY;
         end
         default: res.status = ST_BUSY;
      endcase
      res.count_value = sem_count;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      if (mismatch_total < 40)
         $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, exp_val);
      mismatch_total++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sem_limit    = MAX_COUNT_RESET;
         sem_count    = MAX_COUNT_RESET;
         head_idx     = 0;
         tail_idx     = 0;
         waiter_total = 0;
         expected_rsps.delete();
      end else begin
         // a zero limit is ignored
         if (csr_wr_en && csr_wr_data != '0) begin
            sem_limit = csr_wr_data;
            sem_count = csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_data), 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.count_value !== want.count_value)
                  report_mismatch("count_value", 32'(rsp_data.count_value),
                                  32'(want.count_value));
               if (rsp_data.woken_valid !== want.woken_valid)
                  report_mismatch("woken_valid", 32'(rsp_data.woken_valid),
                                  32'(want.woken_valid));
               if (rsp_data.woken_thread !== want.woken_thread)
                  report_mismatch("woken_thread", 32'(rsp_data.woken_thread),
                                  32'(want.woken_thread));
            end
         end
         if (req_valid && !req_stall)
            expected_rsps.push_back(serve_request(req_data));
      end
      pending_count <= expected_rsps.size();
   end

endmodule

@@ sim/counting_semaphore_fifo_waiters_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_top_tb
// Drives semaphore requests and limit writes: a directed opening, then phases
// of random requests that fill and drain the waiter queue under several
// limits and stall patterns. A side checker predicts and compares results.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_top_tb;
   import csfw_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 19;
   localparam int PHASE_ITEMS = 60;
   localparam int HOLD_CYCLES = 80;
   localparam logic [FUNC_WIDTH-1:0] FUNC_FIRST_UNUSED = FUNC_DESTROY + 1'b1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_LAST_UNUSED  = '1;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   req_type                req_data    = '0;
   logic                   rsp_stall   = 1'b0;
   logic                   csr_wr_en   = 1'b0;
   logic [COUNT_WIDTH-1:0] csr_wr_data = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   int                     fail_count;
   int                     pending_count;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_req      = 1'b0;
   logic hold_taken    = 1'b0;
   int   hold_left     = 0;
   int   cycle_total   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   counting_semaphore_fifo_waiters_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   semaphore_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      cycle_total <= cycle_total + 1;
      if (cycle_total >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random stall, plus one long hold-off to back the block up
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_item(input logic [FUNC_WIDTH-1:0] func, input logic [ID_WIDTH-1:0] tid);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{func: func, thread_id: tid};
      do @(posedge clock); while (req_stall);
   endtask

   // only with the block drained
   task automatic write_limit(input logic [COUNT_WIDTH-1:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [FUNC_WIDTH-1:0] pick_func(input int wait_pct, input int post_pct);
      int r;
      r = $urandom_range(99);
      if (r < 4) return FUNC_WIDTH'($urandom_range(FUNC_LAST_UNUSED, FUNC_FIRST_UNUSED));
      if (r < 4 + wait_pct) return FUNC_WAIT;
      if (r < 4 + wait_pct + post_pct) return FUNC_POST;
      case ($urandom_range(2))
         0:       return FUNC_TRYWAIT;
         1:       return FUNC_GETVALUE;
         default: return FUNC_DESTROY;
      endcase
   endfunction

   initial begin
      int                     phase_idx;
      int                     wait_pct;
      int                     post_pct;
      logic [COUNT_WIDTH-1:0] limit_val;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset limit is one: saturate, drain, block, wake in order
      send_item(FUNC_GETVALUE, 8'h00);
      send_item(FUNC_DESTROY,  8'h00);
      send_item(FUNC_POST,     8'h00);
      send_item(FUNC_WAIT,     8'h00);
      send_item(FUNC_DESTROY,  8'h00);
      send_item(FUNC_TRYWAIT,  8'hff);
      send_item(FUNC_WAIT,     8'hff);
      send_item(FUNC_WAIT,     8'h5a);
      send_item(FUNC_WAIT,     8'ha5);
      send_item(FUNC_POST,     8'h00);
      for (int f = FUNC_FIRST_UNUSED; f <= FUNC_LAST_UNUSED; f++)
         send_item(FUNC_WIDTH'(f), 8'hff);
      send_item(FUNC_POST,     8'h00);

      // zero write is dropped; full-scale reload leaves the waiter queued
      write_limit('0);
      send_item(FUNC_GETVALUE, 8'h00);
      write_limit('1);
      send_item(FUNC_GETVALUE, 8'h00);
      send_item(FUNC_WAIT,     8'h3c);
      send_item(FUNC_POST,     8'h00);
      send_item(FUNC_POST,     8'h00);
      send_item(FUNC_POST,     8'h00);
      send_item(FUNC_DESTROY,  8'h00);

      for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
         if (phase_idx < 6) begin
            send_idle_pct  = 20;
            recv_idle_pct <= 68;
         end else if (phase_idx < 12) begin
            send_idle_pct  = 68;
            recv_idle_pct <= 20;
         end else begin
            send_idle_pct  = 0;
            recv_idle_pct <= 0;
         end
         case (phase_idx % 7)
            0:       limit_val = COUNT_WIDTH'(1);
            4:       limit_val = '1;
            5:       limit_val = '0;
            6:       limit_val = COUNT_WIDTH'($urandom_range(65535, 6));
            default: limit_val = COUNT_WIDTH'($urandom_range(5, 2));
         endcase
         write_limit(limit_val);
         if (phase_idx == 13) hold_req <= 1'b1;
         case (phase_idx % 3)
            0: begin wait_pct = 55; post_pct = 25; end
            1: begin wait_pct = 15; post_pct = 65; end
            default: begin wait_pct = 35; post_pct = 35; end
         endcase
         repeat (PHASE_ITEMS)
            send_item(pick_func(wait_pct, post_pct), ID_WIDTH'($urandom_range(255)));
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
